@@ hdl/msc_pkg.sv @@
// shared types and codes of the mark stack cycle detector
package msc_pkg;

    localparam int OBJ_W   = 32;
    localparam int DEPTH_W = 9;

    // command codes of an input beat
    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_CHECK = 2'd1,
        CMD_MARK  = 2'd2,
        CMD_POP   = 2'd3
    } cmd_t;

    // status codes of a result beat
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INACTIVE = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOMARK   = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_POP,
        S_EMIT
    } state_t;

    // shift operation applied to the whole row of cells
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_PUSH,
        OP_POP
    } shift_op_t;

    // control broadcast to every cell
    typedef struct packed {
        shift_op_t          op;
        logic [OBJ_W-1:0]   key;
    } cell_ctl_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic valid;
        logic hit;
    } token_t;

endpackage

@@ hdl/msc_req_if.sv @@
// command channel: valid/ready handshake with command payload
interface msc_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 cmd;
    logic [msc_pkg::OBJ_W-1:0]  obj_number;

    modport source (output valid, output cmd, output obj_number, input ready);
    modport sink   (input valid, input cmd, input obj_number, output ready);
endinterface

@@ hdl/msc_rsp_if.sv @@
// result channel: valid/ready handshake with result payload
interface msc_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           found;
    logic [1:0]                     status;
    logic [msc_pkg::DEPTH_W-1:0]    depth_now;

    modport source (output valid, output found, output status, output depth_now, input ready);
    modport sink   (input valid, input found, input status, input depth_now, output ready);
endinterface

@@ hdl/msc_cell.sv @@
// one stack cell: holds one entry, shifts with its neighbors, passes the search token
module msc_cell #(
    parameter int CW  = 9,
    parameter int IDX = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  msc_pkg::cell_ctl_t          ctl,
    input  logic [CW-1:0]               count,
    input  logic [msc_pkg::OBJ_W-1:0]   above,
    input  logic [msc_pkg::OBJ_W-1:0]   below,
    output logic [msc_pkg::OBJ_W-1:0]   entry,
    input  msc_pkg::token_t             tok_in,
    output msc_pkg::token_t             tok_out
);

    logic [msc_pkg::OBJ_W-1:0] entry_reg;
    logic [msc_pkg::OBJ_W-1:0] entry_next;
    msc_pkg::token_t           tok_reg;
    msc_pkg::token_t           tok_next;
    logic                      live;

    // this cell holds a stored entry
    assign live = (CW'(IDX) < count);

    // entry moves down on push, up on pop
    always_comb
    begin
        case (ctl.op)
            msc_pkg::OP_PUSH: entry_next = above;
            msc_pkg::OP_POP:  entry_next = below;
            default:          entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // token picks up a match against the broadcast key
    always_comb
    begin
        tok_next.valid = tok_in.valid;
        tok_next.hit   = tok_in.hit | (tok_in.valid & live & (entry_reg == ctl.key));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign entry   = entry_reg;
    assign tok_out = tok_reg;

endmodule

@@ hdl/mark_stack_cycle_detector.sv @@
// top level: row of stack cells with a sequencer and an output register
// push, mark and refused commands: go from idle straight to the emit state, then to the output register
// check: the result waits for the token to walk the full row of cells
// pop to mark: token walk as for check, then the entries are removed at one shift per cycle
// one command at a time; a new command is taken while the last result waits
// reset: empty stack, detector off, no token, no result; entries are not cleared
module mark_stack_cycle_detector #(
    parameter int STACK_DEPTH = 256
) (
    input  logic    clk,
    input  logic    rst_n,
    msc_req_if.sink  req,
    msc_rsp_if.source rsp
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    msc_pkg::state_t            state_reg;
    msc_pkg::state_t            state_next;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic                       active_reg;
    logic                       active_next;
    msc_pkg::cmd_t              cmd_reg;
    msc_pkg::cmd_t              cmd_next;
    logic [msc_pkg::OBJ_W-1:0]  key_reg;
    logic [msc_pkg::OBJ_W-1:0]  key_next;
    logic                       res_found_reg;
    logic                       res_found_next;
    msc_pkg::status_t           res_status_reg;
    msc_pkg::status_t           res_status_next;

    logic                           rsp_valid_reg;
    logic                           rsp_valid_next;
    logic                           rsp_found_reg;
    msc_pkg::status_t               rsp_status_reg;
    logic [msc_pkg::DEPTH_W-1:0]    rsp_depth_reg;

    msc_pkg::cell_ctl_t         ctl;
    msc_pkg::shift_op_t         op;
    logic [msc_pkg::OBJ_W-1:0]  push_data;
    logic                       inject;
    logic                       accept;
    logic                       full;
    logic                       load;
    msc_pkg::cmd_t              in_cmd;

    logic [msc_pkg::OBJ_W-1:0]  entry [STACK_DEPTH];
    msc_pkg::token_t            tok   [STACK_DEPTH+1];

    assign in_cmd    = msc_pkg::cmd_t'(req.cmd);
    assign req.ready = (state_reg == msc_pkg::S_IDLE);
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CW'(STACK_DEPTH));
    assign push_data = (in_cmd == msc_pkg::CMD_MARK) ? '0 : req.obj_number;
    assign load      = (state_reg == msc_pkg::S_EMIT) && (!rsp_valid_reg || rsp.ready);

    assign ctl.op  = op;
    assign ctl.key = key_reg;

    // search token enters at the top of the stack
    assign tok[0].valid = inject;
    assign tok[0].hit   = 1'b0;

    // row of cells, cell 0 is the top of the stack
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic [msc_pkg::OBJ_W-1:0] above;
        logic [msc_pkg::OBJ_W-1:0] below;

        if (i == 0)
        begin : g_top
            assign above = push_data;
        end
        else
        begin : g_mid
            assign above = entry[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_end
            assign below = '0;
        end
        else
        begin : g_inner
            assign below = entry[i+1];
        end

        msc_cell #(
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .count   (count_reg),
            .above   (above),
            .below   (below),
            .entry   (entry[i]),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            msc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (active_reg &&
                        ((in_cmd == msc_pkg::CMD_CHECK) || (in_cmd == msc_pkg::CMD_POP)))
                    begin
                        state_next = msc_pkg::S_START;
                    end
                    else
                    begin
                        state_next = msc_pkg::S_EMIT;
                    end
                end
            end
            msc_pkg::S_START:
            begin
                state_next = msc_pkg::S_SCAN;
            end
            msc_pkg::S_SCAN:
            begin
                if (tok[STACK_DEPTH].valid)
                begin
                    if ((cmd_reg == msc_pkg::CMD_POP) && tok[STACK_DEPTH].hit)
                    begin
                        state_next = msc_pkg::S_POP;
                    end
                    else
                    begin
                        state_next = msc_pkg::S_EMIT;
                    end
                end
            end
            msc_pkg::S_POP:
            begin
                if (entry[0] == '0)
                begin
                    state_next = msc_pkg::S_EMIT;
                end
            end
            msc_pkg::S_EMIT:
            begin
                if (load)
                begin
                    state_next = msc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = msc_pkg::S_IDLE;
            end
        endcase
    end

    // datapath control and results
    always_comb
    begin
        count_next      = count_reg;
        active_next     = active_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        op              = msc_pkg::OP_HOLD;
        inject          = 1'b0;
        case (state_reg)
            msc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next        = in_cmd;
                    res_found_next  = 1'b0;
                    res_status_next = msc_pkg::ST_OK;
                    case (in_cmd)
                        msc_pkg::CMD_PUSH:
                        begin
                            if (!active_reg)
                            begin
                                res_status_next = msc_pkg::ST_INACTIVE;
                            end
                            else if (full)
                            begin
                                res_status_next = msc_pkg::ST_FULL;
                            end
                            else
                            begin
                                op         = msc_pkg::OP_PUSH;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        msc_pkg::CMD_MARK:
                        begin
                            if (!active_reg)
                            begin
                                // first mark turns the detector on over an empty stack
                                active_next = 1'b1;
                                op          = msc_pkg::OP_PUSH;
                                count_next  = CW'(1);
                            end
                            else if (full)
                            begin
                                res_status_next = msc_pkg::ST_FULL;
                            end
                            else
                            begin
                                op         = msc_pkg::OP_PUSH;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        msc_pkg::CMD_CHECK:
                        begin
                            key_next = req.obj_number;
                            if (!active_reg)
                            begin
                                res_status_next = msc_pkg::ST_INACTIVE;
                            end
                        end
                        msc_pkg::CMD_POP:
                        begin
                            // a pop first looks for any mark in the stack
                            key_next = '0;
                            if (!active_reg)
                            begin
                                res_status_next = msc_pkg::ST_INACTIVE;
                            end
                        end
                        default:
                        begin
                            res_status_next = msc_pkg::ST_OK;
                        end
                    endcase
                end
            end
            msc_pkg::S_START:
            begin
                inject = 1'b1;
            end
            msc_pkg::S_SCAN:
            begin
                if (tok[STACK_DEPTH].valid)
                begin
                    if (cmd_reg == msc_pkg::CMD_CHECK)
                    begin
                        res_found_next = tok[STACK_DEPTH].hit;
                    end
                    else if (!tok[STACK_DEPTH].hit)
                    begin
                        res_status_next = msc_pkg::ST_NOMARK;
                    end
                end
            end
            msc_pkg::S_POP:
            begin
                // remove the top entry, stop after the mark
                op         = msc_pkg::OP_POP;
                count_next = count_reg - 1'b1;
                if ((entry[0] == '0) && (count_reg == CW'(1)))
                begin
                    active_next = 1'b0;
                end
            end
            default:
            begin
                op = msc_pkg::OP_HOLD;
            end
        endcase
    end

    // output register
    assign rsp_valid_next = (rsp_valid_reg && !rsp.ready) || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msc_pkg::S_IDLE;
            count_reg     <= '0;
            active_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            active_reg    <= active_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // command payload and result beat
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        if (load)
        begin
            rsp_found_reg  <= res_found_reg;
            rsp_status_reg <= res_status_reg;
            rsp_depth_reg  <= msc_pkg::DEPTH_W'(count_reg);
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.found     = rsp_found_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.depth_now = rsp_depth_reg;

endmodule

@@ hdl/msc_checker.sv @@
// port checker for the mark stack cycle detector and its bind
module msc_checker #(
    parameter int STACK_DEPTH = 256
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic                         rsp_found,
    input logic [1:0]                   rsp_status,
    input logic [msc_pkg::DEPTH_W-1:0]  rsp_depth_now
);

    // a stalled result beat stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result beat dropped while stalled");

    // found only comes with a successful check
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_found |-> rsp_status == msc_pkg::ST_OK)
        else $error("found set with an error status");

    // a full stack reports the full depth
    a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == msc_pkg::ST_FULL) |->
            rsp_depth_now == msc_pkg::DEPTH_W'(STACK_DEPTH))
        else $error("full status with wrong depth");

    // an inactive detector holds no entries
    a_inactive_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == msc_pkg::ST_INACTIVE) |-> rsp_depth_now == '0)
        else $error("inactive status with stored entries");

endmodule

bind mark_stack_cycle_detector msc_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_msc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_found     (rsp.found),
    .rsp_status    (rsp.status),
    .rsp_depth_now (rsp.depth_now)
);
